/* rtl/core/qrv_pkg.sv */
`timescale 1ns / 1ps
// qrv_pkg: shared types and constants for the quaternion point rotation core
// no dependencies

package qrv_pkg;

  localparam int REG_BITS     = 16;
  localparam int CFG_IDX_BITS = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ROT_X = 2'd0,
    CFG_ROT_Y = 2'd1,
    CFG_ROT_Z = 2'd2,
    CFG_ROT_W = 2'd3
  } cfg_idx_t;

  typedef logic signed [REG_BITS-1:0] quat_comp_t;

  typedef struct packed {
    quat_comp_t x;
    quat_comp_t y;
    quat_comp_t z;
    quat_comp_t w;
  } quat_t;

endpackage

/* rtl/core/qrv_ifs.sv */
`timescale 1ns / 1ps
// qrv_ifs: valid/ready channel interfaces for the point input and the rotated output
// no dependencies

interface qrv_pt_if #(
  parameter int W = 24
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] pt_x;
  logic signed [W-1:0] pt_y;
  logic signed [W-1:0] pt_z;

  modport source (output valid, output pt_x, output pt_y, output pt_z, input ready);
  modport sink   (input valid, input pt_x, input pt_y, input pt_z, output ready);
endinterface

interface qrv_res_if #(
  parameter int W = 24
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] out_x;
  logic signed [W-1:0] out_y;
  logic signed [W-1:0] out_z;

  modport source (output valid, output out_x, output out_y, output out_z, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

/* rtl/core/quaternion_rotate_vector_core.sv */
`timescale 1ns / 1ps
// Rotates one signed 3-D point per clock by the quaternion held in the rot_x/y/z/w
// registers (signed Q(15-QUAT_FRAC_BITS).QUAT_FRAC_BITS), computing q*(p,0)*conj(q)
// with each product rounded to nearest and the result saturated to COORD_BITS. A
// non-unit quaternion scales the point by its squared length. A multiply stage and
// an add/round stage serve each of the two Hamilton products; one point is accepted
// every cycle while the output is taken; a stall backs up the stages without loss.
// The user must write registers only when no point is in flight; it is not enforced.
// depends on qrv_pkg and qrv_ifs

module quaternion_rotate_vector_core #(
  parameter int COORD_BITS     = 24,
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  qrv_pkg::cfg_idx_t    cfg_index,
  input  qrv_pkg::quat_comp_t  cfg_data,
  qrv_pt_if.sink               pt_in,
  qrv_res_if.source            res_out
);
  import qrv_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int F  = QUAT_FRAC_BITS;
  // first product: 16 x C bit terms, three summed plus rounding constant
  localparam int PW1 = C + REG_BITS;
  localparam int SW1 = (C + 18 > F + 2) ? C + 18 : F + 2;
  localparam int TW  = SW1 - F;
  // second product: TW x 16 bit terms, four summed plus rounding constant
  localparam int PW2 = TW + REG_BITS;
  localparam int SW2 = (PW2 + 3 > F + 2) ? PW2 + 3 : F + 2;

  localparam logic signed [SW1-1:0] HALF1 = SW1'(1) << (F - 1);
  localparam logic signed [SW2-1:0] HALF2 = SW2'(1) << (F - 1);
  localparam logic signed [SW2-1:0] OMAX  = {{(SW2-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [SW2-1:0] OMIN  = ~OMAX;
  localparam quat_comp_t ROT_W_RST = (F < REG_BITS - 1) ?
                                     REG_BITS'(32'd1 << F) : quat_comp_t'(16'sh7fff);

  // configuration registers
  quat_t q;

  always_ff @(posedge clk) begin
    if (rst) begin
      q.x <= '0;
      q.y <= '0;
      q.z <= '0;
      q.w <= ROT_W_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ROT_X: q.x <= cfg_data;
        CFG_ROT_Y: q.y <= cfg_data;
        CFG_ROT_Z: q.z <= cfg_data;
        CFG_ROT_W: q.w <= cfg_data;
      endcase
    end
  end

  // pipeline control: a stage loads when empty or when its contents move on
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4 || res_out.ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign pt_in.ready   = rdy1;
  assign res_out.valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= pt_in.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // stage 1: products of q * (p,0)
  logic signed [PW1-1:0] m1 [12];

  always_ff @(posedge clk) begin
    if (rdy1) begin
      m1[0]  <= PW1'(q.y) * PW1'(pt_in.pt_z);
      m1[1]  <= PW1'(q.z) * PW1'(pt_in.pt_y);
      m1[2]  <= PW1'(q.w) * PW1'(pt_in.pt_x);
      m1[3]  <= PW1'(q.z) * PW1'(pt_in.pt_x);
      m1[4]  <= PW1'(q.x) * PW1'(pt_in.pt_z);
      m1[5]  <= PW1'(q.w) * PW1'(pt_in.pt_y);
      m1[6]  <= PW1'(q.x) * PW1'(pt_in.pt_y);
      m1[7]  <= PW1'(q.y) * PW1'(pt_in.pt_x);
      m1[8]  <= PW1'(q.w) * PW1'(pt_in.pt_z);
      m1[9]  <= PW1'(q.x) * PW1'(pt_in.pt_x);
      m1[10] <= PW1'(q.y) * PW1'(pt_in.pt_y);
      m1[11] <= PW1'(q.z) * PW1'(pt_in.pt_z);
    end
  end

  // stage 2: sum and round to t
  logic signed [SW1-1:0] s1 [4];
  logic signed [TW-1:0]  t  [4];

  always_comb begin
    s1[0] = SW1'(m1[0]) - SW1'(m1[1]) + SW1'(m1[2]) + HALF1;
    s1[1] = SW1'(m1[3]) - SW1'(m1[4]) + SW1'(m1[5]) + HALF1;
    s1[2] = SW1'(m1[6]) - SW1'(m1[7]) + SW1'(m1[8]) + HALF1;
    s1[3] = HALF1 - SW1'(m1[9]) - SW1'(m1[10]) - SW1'(m1[11]);
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int i = 0; i < 4; i++) begin
        t[i] <= TW'(s1[i] >>> F);
      end
    end
  end

  // stage 3: products of t * conj(q), conjugate signs folded into the sums
  logic signed [PW2-1:0] m2 [12];

  always_ff @(posedge clk) begin
    if (rdy3) begin
      m2[0]  <= PW2'(t[1]) * PW2'(q.z);
      m2[1]  <= PW2'(t[2]) * PW2'(q.y);
      m2[2]  <= PW2'(t[3]) * PW2'(q.x);
      m2[3]  <= PW2'(t[0]) * PW2'(q.w);
      m2[4]  <= PW2'(t[2]) * PW2'(q.x);
      m2[5]  <= PW2'(t[0]) * PW2'(q.z);
      m2[6]  <= PW2'(t[3]) * PW2'(q.y);
      m2[7]  <= PW2'(t[1]) * PW2'(q.w);
      m2[8]  <= PW2'(t[0]) * PW2'(q.y);
      m2[9]  <= PW2'(t[1]) * PW2'(q.x);
      m2[10] <= PW2'(t[3]) * PW2'(q.z);
      m2[11] <= PW2'(t[2]) * PW2'(q.w);
    end
  end

  // stage 4: sum, round, saturate
  logic signed [SW2-1:0] s2 [3];
  logic signed [SW2-1:0] r2 [3];
  logic signed [C-1:0]   o  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2[i] = SW2'(m2[4*i+1]) - SW2'(m2[4*i]) - SW2'(m2[4*i+2]) + SW2'(m2[4*i+3]) + HALF2;
      r2[i] = s2[i] >>> F;
      priority if (r2[i] > OMAX) begin
        o[i] = C'(OMAX);
      end else if (r2[i] < OMIN) begin
        o[i] = C'(OMIN);
      end else begin
        o[i] = C'(r2[i]);
      end
    end
  end

  logic signed [C-1:0] res [3];

  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int i = 0; i < 3; i++) begin
        res[i] <= o[i];
      end
    end
  end

  assign res_out.out_x = res[0];
  assign res_out.out_y = res[1];
  assign res_out.out_z = res[2];

  // an accepted beat always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (pt_in.valid && pt_in.ready) |=> v1)
    else $error("accepted beat did not enter stage 1");

  // input backpressure only when every stage is full
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !pt_in.ready |-> (v1 && v2 && v3 && v4))
    else $error("input stalled with a bubble in the pipe");

  // a held middle stage keeps its beat
  a_hold_mid: assert property (@(posedge clk) disable iff (rst)
    (v3 && !rdy4) |=> v3)
    else $error("stage 3 beat lost under stall");

  // a stalled result stays valid
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (v4 && !res_out.ready) |=> v4)
    else $error("output beat dropped under stall");

endmodule
